FILE: sv/mexp_pkg.sv
package mexp_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_EXPONENT = 1'd0;
  localparam cfg_index_t REG_MODULUS  = 1'd1;

  // modular multiply operations run on the shared bit-serial unit
  typedef logic [1:0] op_t;
  localparam op_t OP_REDUCE = 2'd0;
  localparam op_t OP_MULT   = 2'd1;
  localparam op_t OP_SQUARE = 2'd2;

  typedef struct packed {
    logic load;
    logic op_start;
    logic op_step;
    logic op_commit;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
  } status_t;

endpackage

FILE: sv/mexp_dpath.sv
module mexp_dpath #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  mexp_pkg::cmd_t    cmd,
  output mexp_pkg::status_t status,
  input  logic [WIDTH-1:0]  block_value,
  input  logic [WIDTH-1:0]  exponent,
  input  logic [WIDTH-1:0]  modulus,
  output logic [WIDTH-1:0]  power_result
);

  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] res;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] opa;
  logic [WIDTH-1:0] opb;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] acc_next;

  // (x + y) mod m for x < m; y == m == 1 also gives 0
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  // one Horner step: double, then add the operand when the multiplier bit is set
  always_comb begin
    dbl = add_mod(acc, acc, modulus);
    acc_next = opb[WIDTH-1] ? add_mod(dbl, opa, modulus) : dbl;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= block_value;
      e    <= exponent;
      res  <= WIDTH'(1);
    end
    if (cmd.op_start) begin
      acc <= '0;
      // reduction is 1 * base, which is base mod m
      opa <= (cmd.op == mexp_pkg::OP_REDUCE) ? WIDTH'(1) : base;
      opb <= (cmd.op == mexp_pkg::OP_MULT) ? res : base;
    end else if (cmd.op_step) begin
      acc <= acc_next;
      opb <= {opb[WIDTH-2:0], 1'b0};
    end
    if (cmd.op_commit) begin
      case (cmd.op)
        mexp_pkg::OP_REDUCE: base <= acc;
        mexp_pkg::OP_MULT: begin
          res  <= acc;
          e[0] <= 1'b0;
        end
        mexp_pkg::OP_SQUARE: begin
          base <= acc;
          e    <= {1'b0, e[WIDTH-1:1]};
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      power_result <= res;
    end
  end

  assign status.e_zero = (e == '0);
  assign status.e_lsb  = e[0];

endmodule

FILE: sv/mexp_ctrl.sv
module mexp_ctrl #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_NEXT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;
  mexp_pkg::op_t   cur_op;
  mexp_pkg::op_t   cur_op_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cur_op_next  = cur_op;
    cmd          = '0;
    cmd.op       = cur_op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (status.e_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.op_start = 1'b1;
          cmd.op       = mexp_pkg::OP_REDUCE;
          cur_op_next  = mexp_pkg::OP_REDUCE;
          cnt_next     = '0;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        cmd.op_step = 1'b1;
        cnt_next    = cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op_commit = 1'b1;
        state_next    = S_NEXT;
      end
      S_NEXT: begin
        // multiply in on a set bit, then square while exponent bits remain
        if (status.e_lsb) begin
          cmd.op_start = 1'b1;
          cmd.op       = mexp_pkg::OP_MULT;
          cur_op_next  = mexp_pkg::OP_MULT;
          cnt_next     = '0;
          state_next   = S_RUN;
        end else if (status.e_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.op_start = 1'b1;
          cmd.op       = mexp_pkg::OP_SQUARE;
          cur_op_next  = mexp_pkg::OP_SQUARE;
          cnt_next     = '0;
          state_next   = S_RUN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cur_op    <= mexp_pkg::OP_REDUCE;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      cur_op <= cur_op_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/modular_exponentiation.sv
// a zero exponent skips the multiplies; otherwise one reduction, then L squarings and K multiplies,
//   L = index of the top set exponent bit, K = number of set exponent bits
// each modular multiply is a bit-serial shift-and-add over the multiplier bits
// one word at a time; the next word is taken while a result waits at the output
// synchronous reset: idle, no output word, exponent 0, modulus 1
module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [WIDTH-1:0]              block_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [WIDTH-1:0]              power_result,
  input  logic                          cfg_write,
  input  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]              cfg_data
);

  logic [WIDTH-1:0]  exponent;
  logic [WIDTH-1:0]  modulus;
  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  // modulus can never be zero, a zero write is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        mexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        mexp_pkg::REG_MODULUS: begin
          if (cfg_data != '0) begin
            modulus <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  mexp_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_dpath #(
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .block_value (block_value),
    .exponent    (exponent),
    .modulus     (modulus),
    .power_result(power_result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a word");

  a_modulus_nonzero: assert property (@(posedge clk) disable iff (rst)
    modulus != '0)
    else $error("modulus register holds zero");

  a_zero_write_dropped: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == mexp_pkg::REG_MODULUS && cfg_data == '0
    |=> $stable(modulus))
    else $error("zero modulus write changed the register");

endmodule
